FILE: rtl/esm_pkg.sv
// ----------------------------------------------------------------------------
// esm_pkg
// Shared types, codes and helpers for the EJTAG scan event monitor.
// ----------------------------------------------------------------------------
package esm_pkg;

   // scan event operations
   localparam logic [1:0] OP_IR_SHIFT  = 2'd0;
   localparam logic [1:0] OP_DR_IN     = 2'd1;
   localparam logic [1:0] OP_DR_OUT    = 2'd2;
   localparam logic [1:0] OP_UPDATE    = 2'd3;

   // record kinds
   localparam logic [2:0] KIND_INSTR    = 3'd0;
   localparam logic [2:0] KIND_REGISTER = 3'd1;
   localparam logic [2:0] KIND_WORD_IN  = 3'd2;
   localparam logic [2:0] KIND_WORD_OUT = 3'd3;
   localparam logic [2:0] KIND_FAST_IN  = 3'd4;
   localparam logic [2:0] KIND_FAST_OUT = 3'd5;
   localparam logic [2:0] KIND_ACCESS   = 3'd6;

   // register ids
   localparam logic [3:0] REG_RESET    = 4'd0;
   localparam logic [3:0] REG_ID       = 4'd1;
   localparam logic [3:0] REG_IMPL     = 4'd2;
   localparam logic [3:0] REG_DATA     = 4'd3;
   localparam logic [3:0] REG_ADDRESS  = 4'd4;
   localparam logic [3:0] REG_CONTROL  = 4'd5;
   localparam logic [3:0] REG_FASTDATA = 4'd6;

   // instruction codes
   localparam logic [7:0] IR_IDCODE   = 8'h01;
   localparam logic [7:0] IR_IMPCODE  = 8'h03;
   localparam logic [7:0] IR_ADDRESS  = 8'h08;
   localparam logic [7:0] IR_DATA     = 8'h09;
   localparam logic [7:0] IR_CONTROL  = 8'h0A;
   localparam logic [7:0] IR_FASTDATA = 8'h0E;
   localparam logic [7:0] IR_LIST_LO_MAX = 8'h03;
   localparam logic [7:0] IR_LIST_MID_MIN = 8'h08;
   localparam logic [7:0] IR_LIST_MID_MAX = 8'h17;
   localparam logic [7:0] IR_LIST_EXTRA = 8'h1C;

   // control register bits
   localparam int PRACC_BIT = 18;
   localparam int PRNW_BIT  = 19;

   localparam int MAX_RECORDS = 4;
   localparam int REC_IDX_W   = $clog2(MAX_RECORDS);
   localparam int REC_CNT_W   = REC_IDX_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  register_id;
      logic [31:0] word;
      logic [31:0] access_address;
      logic        access_store;
      logic        access_data_seen;
      logic        code_known;
      logic        last_record;
   } rsp_type;

   typedef struct packed {
      logic [REC_CNT_W-1:0]         count;
      rsp_type [MAX_RECORDS-1:0]    rec;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic code_in_list(input logic [7:0] c);
      return (c <= IR_LIST_LO_MAX) ||
             ((c >= IR_LIST_MID_MIN) && (c <= IR_LIST_MID_MAX)) ||
             (c == IR_LIST_EXTRA);
   endfunction

   function automatic logic [3:0] select_for(input logic [7:0] c);
      logic [3:0] r;
      case (c)
         IR_IDCODE:   r = REG_ID;
         IR_IMPCODE:  r = REG_IMPL;
         IR_DATA:     r = REG_DATA;
         IR_ADDRESS:  r = REG_ADDRESS;
         IR_CONTROL:  r = REG_CONTROL;
         IR_FASTDATA: r = REG_FASTDATA;
         default:     r = REG_RESET;
      endcase
      return r;
   endfunction

   function automatic rsp_type make_rec(input logic [2:0] kind, input logic [3:0] reg_id,
                                        input logic [31:0] word, input logic [31:0] addr,
                                        input logic store, input logic seen,
                                        input logic known);
      rsp_type r;
      r.kind             = kind;
      r.register_id      = reg_id;
      r.word             = word;
      r.access_address   = addr;
      r.access_store     = store;
      r.access_data_seen = seen;
      r.code_known       = known;
      r.last_record      = 1'b0;
      return r;
   endfunction

endpackage

FILE: rtl/esm_front.sv
// ----------------------------------------------------------------------------
// esm_front
// Accepts scan events, keeps the monitor state and builds the record job.
// ----------------------------------------------------------------------------
module esm_front
   import esm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_type      req,
   output logic         push,
   output job_type      job
);

   logic [3:0]  sel_ff, sel_in;
   logic [31:0] cin_ff, cin_in;
   logic [31:0] cout_ff, cout_in;
   logic        cin_seen_ff, cin_seen_in;
   logic        cout_seen_ff, cout_seen_in;
   logic [31:0] aaddr_ff, aaddr_in;
   logic [31:0] adin_ff, adin_in;
   logic [31:0] adout_ff, adout_in;
   logic        ain_seen_ff, ain_seen_in;
   logic        aout_seen_ff, aout_seen_in;

   always_comb begin
      logic [REC_CNT_W-1:0] n;
      logic [7:0]           code;
      logic                 store;
      sel_in       = sel_ff;
      cin_in       = cin_ff;
      cout_in      = cout_ff;
      cin_seen_in  = cin_seen_ff;
      cout_seen_in = cout_seen_ff;
      aaddr_in     = aaddr_ff;
      adin_in      = adin_ff;
      adout_in     = adout_ff;
      ain_seen_in  = ain_seen_ff;
      aout_seen_in = aout_seen_ff;
      job          = '0;
      n            = '0;
      code         = req.value[7:0];
      store        = cout_ff[PRNW_BIT];
      case (req.operation)
         OP_IR_SHIFT: begin
            sel_in = select_for(code);
            job.rec[n[REC_IDX_W-1:0]] = make_rec(KIND_INSTR, select_for(code),
                                                 {24'd0, code}, '0, 1'b0, 1'b0,
                                                 code_in_list(code));
            n = n + 1'b1;
         end
         OP_DR_IN: begin
            cin_in      = req.value;
            cin_seen_in = 1'b1;
            if (sel_ff == REG_DATA) begin
               adin_in     = req.value;
               ain_seen_in = 1'b1;
            end else if (sel_ff == REG_FASTDATA) begin
               job.rec[n[REC_IDX_W-1:0]] = make_rec(KIND_FAST_IN, sel_ff, req.value,
                                                    '0, 1'b0, 1'b0, 1'b0);
               n = n + 1'b1;
            end
         end
         OP_DR_OUT: begin
            cout_in      = req.value;
            cout_seen_in = 1'b1;
            if (sel_ff == REG_ADDRESS) begin
               aaddr_in = req.value;
            end else if (sel_ff == REG_DATA) begin
               adout_in     = req.value;
               aout_seen_in = 1'b1;
            end else if (sel_ff == REG_FASTDATA) begin
               job.rec[n[REC_IDX_W-1:0]] = make_rec(KIND_FAST_OUT, sel_ff, req.value,
                                                    '0, 1'b0, 1'b0, 1'b0);
               n = n + 1'b1;
            end
         end
         OP_UPDATE: begin
            if (sel_ff != REG_RESET) begin
               job.rec[n[REC_IDX_W-1:0]] = make_rec(KIND_REGISTER, sel_ff, '0, '0,
                                                    1'b0, 1'b0, 1'b0);
               n = n + 1'b1;
               if ((sel_ff == REG_ID) || (sel_ff == REG_IMPL)) begin
                  if (cout_seen_ff) begin
                     job.rec[n[REC_IDX_W-1:0]] = make_rec(KIND_WORD_OUT, sel_ff, cout_ff,
                                                          '0, 1'b0, 1'b0, 1'b0);
                     n = n + 1'b1;
                  end
               end else if (sel_ff != REG_FASTDATA) begin
                  if (cin_seen_ff) begin
                     job.rec[n[REC_IDX_W-1:0]] = make_rec(KIND_WORD_IN, sel_ff, cin_ff,
                                                          '0, 1'b0, 1'b0, 1'b0);
                     n = n + 1'b1;
                  end
                  if (cout_seen_ff) begin
                     job.rec[n[REC_IDX_W-1:0]] = make_rec(KIND_WORD_OUT, sel_ff, cout_ff,
                                                          '0, 1'b0, 1'b0, 1'b0);
                     n = n + 1'b1;
                  end
               end
               if ((sel_ff == REG_CONTROL) && !cin_ff[PRACC_BIT] && cout_ff[PRACC_BIT]) begin
                  job.rec[n[REC_IDX_W-1:0]] = make_rec(KIND_ACCESS, REG_CONTROL,
                                                       store ? adout_ff : adin_ff,
                                                       aaddr_ff, store,
                                                       store ? aout_seen_ff : ain_seen_ff,
                                                       1'b0);
                  n            = n + 1'b1;
                  aaddr_in     = '0;
                  adin_in      = '0;
                  adout_in     = '0;
                  ain_seen_in  = 1'b0;
                  aout_seen_in = 1'b0;
               end
               cin_in       = '0;
               cout_in      = '0;
               cin_seen_in  = 1'b0;
               cout_seen_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (n != '0) begin
         job.rec[REC_IDX_W'(n - 1'b1)].last_record = 1'b1;
      end
      job.count = n;
   end

   assign push = accept && (job.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= REG_RESET;
         cin_ff       <= '0;
         cout_ff      <= '0;
         cin_seen_ff  <= 1'b0;
         cout_seen_ff <= 1'b0;
         aaddr_ff     <= '0;
         adin_ff      <= '0;
         adout_ff     <= '0;
         ain_seen_ff  <= 1'b0;
         aout_seen_ff <= 1'b0;
      end else if (accept) begin
         sel_ff       <= sel_in;
         cin_ff       <= cin_in;
         cout_ff      <= cout_in;
         cin_seen_ff  <= cin_seen_in;
         cout_seen_ff <= cout_seen_in;
         aaddr_ff     <= aaddr_in;
         adin_ff      <= adin_in;
         adout_ff     <= adout_in;
         ain_seen_ff  <= ain_seen_in;
         aout_seen_ff <= aout_seen_in;
      end
   end

endmodule

FILE: rtl/esm_queue.sv
// ----------------------------------------------------------------------------
// esm_queue
// Short job queue between the front and the record sequencer.
// ----------------------------------------------------------------------------
module esm_queue
   import esm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head_job,
   output q_status_type status
);

   job_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("push into full job queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("pop from empty job queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("job queue count out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("job queue count did not advance on push");

endmodule

FILE: rtl/esm_back.sv
// ----------------------------------------------------------------------------
// esm_back
// Walks the head job into the result register one record per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module esm_back
   import esm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  job_type      head_job,
   input  q_status_type status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_payload
);

   logic [REC_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 load;
   logic                 last;

   assign load = !valid_ff || !rsp_stall;
   assign last = (REC_CNT_W'(idx_ff) + 1'b1) == head_job.count;
   assign pop  = load && !status.empty && last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in = !status.empty;
         if (!status.empty) begin
            rsp_in = head_job.rec[idx_ff];
            idx_in = last ? '0 : REC_IDX_W'(idx_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && rsp_ff.last_record && (idx_ff == '0)))
      else $error("job retired without its last record");

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !status.empty |-> (REC_CNT_W'(idx_ff) < head_job.count))
      else $error("record index beyond job length");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (valid_ff && $stable(rsp_ff)))
      else $error("stalled record changed");

endmodule

FILE: rtl/ejtag_scan_event_monitor_top.sv
// ----------------------------------------------------------------------------
// ejtag_scan_event_monitor_top
// EJTAG scan event monitor: decodes scan events into instruction, register,
// word, fastdata and processor-access records.
//
//   channel   dir  handshake          payload
//   req_      in   req_valid/stall    req_type  (operation, value)
//   rsp_      out  rsp_valid/stall    rsp_type  (one record per transaction)
//
// Back-to-back events are accepted while the two-entry job queue has room.
// Each job drains one record per cycle, while rsp_stall is low, through
// the result register; an update job holds up to 4 records, other jobs 1.
// Reset clears the monitor state, the queue and the result valid.
// req_stall rises only while the job queue is full.
// ----------------------------------------------------------------------------
module ejtag_scan_event_monitor_top
   import esm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   q_status_type q_status;
   job_type      push_job;
   job_type      head_job;
   logic         push;
   logic         pop;
   logic         accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   esm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (push),
      .job    (push_job)
   );

   esm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   esm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .status      (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: dv/ejtag_scan_event_monitor_top_tb.sv
// ----------------------------------------------------------------------------
// ejtag_scan_event_monitor_top_tb
// Drives IR and DR scan events into the monitor and checks every record it
// emits against a cycle-free prediction of the monitor state. A directed set
// covers each register, the access path and the reset-select cases, followed
// by random scan sequences under three idling mixes and one long output hold.
// ----------------------------------------------------------------------------
module ejtag_scan_event_monitor_top_tb
   import esm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEQ_ITEMS_PER_PHASE = 75;
   localparam int HOLD_CYCLES         = 60;
   localparam int WATCHDOG_LIMIT      = 2000;
   localparam int DRAIN_CYCLES        = 12;
   localparam int MAX_PRINTED         = 40;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   ejtag_scan_event_monitor_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   req_type scan_queue[$];
   rsp_type expected_records[$];
   int      scan_items_queued = 0;
   int      mismatch_count    = 0;
   int      send_idle_pct     = 0;
   int      recv_idle_pct     = 0;
   int      hold_requests     = 0;
   int      hold_served       = 0;
   int      hold_left         = 0;
   int      quiet_cycles      = 0;
   logic    req_fire          = 1'b0;

   // predicted monitor state
   logic [3:0]  sel_reg      = REG_RESET;
   logic [31:0] tdi_word     = '0;
   logic [31:0] tdo_word     = '0;
   logic        tdi_seen     = 1'b0;
   logic        tdo_seen     = 1'b0;
   logic [31:0] pa_addr      = '0;
   logic [31:0] pa_din       = '0;
   logic [31:0] pa_dout      = '0;
   logic        pa_din_seen  = 1'b0;
   logic        pa_dout_seen = 1'b0;

   function automatic logic code_listed(input logic [7:0] code);
      return (code <= IR_LIST_LO_MAX) ||
             (code inside {[IR_LIST_MID_MIN:IR_LIST_MID_MAX]}) ||
             (code == IR_LIST_EXTRA);
   endfunction

   function automatic logic [3:0] register_for_code(input logic [7:0] code);
      case (code)
         IR_IDCODE:   return REG_ID;
         IR_IMPCODE:  return REG_IMPL;
         IR_DATA:     return REG_DATA;
         IR_ADDRESS:  return REG_ADDRESS;
         IR_CONTROL:  return REG_CONTROL;
         IR_FASTDATA: return REG_FASTDATA;
         default:     return REG_RESET;
      endcase
   endfunction

   function automatic rsp_type plain_record(input logic [2:0] kind, input logic [3:0] reg_id,
                                            input logic [31:0] word);
      rsp_type r;
      r             = '0;
      r.kind        = kind;
      r.register_id = reg_id;
      r.word        = word;
      return r;
   endfunction

   task automatic predict_scan(input req_type t);
      rsp_type    recs [MAX_RECORDS];
      int         n;
      logic [3:0] cur;
      logic [7:0] code;
      logic       store;
      n    = 0;
      cur  = sel_reg;
      code = t.value[7:0];
      case (t.operation)
         OP_IR_SHIFT: begin
            sel_reg = register_for_code(code);
            recs[n] = plain_record(KIND_INSTR, sel_reg, {24'd0, code});
            recs[n].code_known = code_listed(code);
            n++;
         end
         OP_DR_IN: begin
            tdi_word = t.value;
            tdi_seen = 1'b1;
            if (cur == REG_DATA) begin
               pa_din      = t.value;
               pa_din_seen = 1'b1;
            end else if (cur == REG_FASTDATA) begin
               recs[n] = plain_record(KIND_FAST_IN, cur, t.value);
               n++;
            end
         end
         OP_DR_OUT: begin
            tdo_word = t.value;
            tdo_seen = 1'b1;
            if (cur == REG_ADDRESS) begin
               pa_addr = t.value;
            end else if (cur == REG_DATA) begin
               pa_dout      = t.value;
               pa_dout_seen = 1'b1;
            end else if (cur == REG_FASTDATA) begin
               recs[n] = plain_record(KIND_FAST_OUT, cur, t.value);
               n++;
            end
         end
         default: begin
            if (cur != REG_RESET) begin
               recs[n] = plain_record(KIND_REGISTER, cur, '0);
               n++;
               if (cur == REG_ID || cur == REG_IMPL) begin
                  if (tdo_seen) begin
                     recs[n] = plain_record(KIND_WORD_OUT, cur, tdo_word);
                     n++;
                  end
               end else if (cur != REG_FASTDATA) begin
                  if (tdi_seen) begin
                     recs[n] = plain_record(KIND_WORD_IN, cur, tdi_word);
                     n++;
                  end
                  if (tdo_seen) begin
                     recs[n] = plain_record(KIND_WORD_OUT, cur, tdo_word);
                     n++;
                  end
               end
               if (cur == REG_CONTROL && !tdi_word[PRACC_BIT] && tdo_word[PRACC_BIT]) begin
                  store   = tdo_word[PRNW_BIT];
                  recs[n] = plain_record(KIND_ACCESS, REG_CONTROL, store ? pa_dout : pa_din);
                  recs[n].access_address   = pa_addr;
                  recs[n].access_store     = store;
                  recs[n].access_data_seen = store ? pa_dout_seen : pa_din_seen;
                  n++;
                  pa_addr      = '0;
                  pa_din       = '0;
                  pa_dout      = '0;
                  pa_din_seen  = 1'b0;
                  pa_dout_seen = 1'b0;
               end
               tdi_word = '0;
               tdo_word = '0;
               tdi_seen = 1'b0;
               tdo_seen = 1'b0;
            end
         end
      endcase
      if (n > 0) begin
         recs[n-1].last_record = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         expected_records.push_back(recs[i]);
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   task automatic check_record(input rsp_type got);
      rsp_type want;
      if (expected_records.size() == 0) begin
         report_mismatch($sformatf("unexpected record %h", got));
         return;
      end
      want = expected_records.pop_front();
      if (got.kind !== want.kind)
         report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.register_id !== want.register_id)
         report_mismatch($sformatf("register_id %0d, expected %0d",
                                   got.register_id, want.register_id));
      if (got.word !== want.word)
         report_mismatch($sformatf("word %h, expected %h", got.word, want.word));
      if (got.access_address !== want.access_address)
         report_mismatch($sformatf("access_address %h, expected %h",
                                   got.access_address, want.access_address));
      if (got.access_store !== want.access_store)
         report_mismatch($sformatf("access_store %b, expected %b",
                                   got.access_store, want.access_store));
      if (got.access_data_seen !== want.access_data_seen)
         report_mismatch($sformatf("access_data_seen %b, expected %b",
                                   got.access_data_seen, want.access_data_seen));
      if (got.code_known !== want.code_known)
         report_mismatch($sformatf("code_known %b, expected %b",
                                   got.code_known, want.code_known));
      if (got.last_record !== want.last_record)
         report_mismatch($sformatf("last_record %b, expected %b",
                                   got.last_record, want.last_record));
   endtask

   // driver: a new transaction only once the held one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (scan_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= scan_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES - 1;
         hold_served <= hold_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) predict_scan(req_payload);
         if (rsp_valid && !rsp_stall) check_record(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL ejtag_scan_event_monitor_top");
         $finish;
      end
   end

   task automatic push_scan(input logic [1:0] op, input logic [31:0] value);
      req_type t;
      t.operation = op;
      t.value     = value;
      scan_queue.push_back(t);
      scan_items_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (scan_queue.size() != 0 || req_valid || expected_records.size() != 0);
   endtask

   task automatic queue_scan_sequence();
      logic [7:0]  code;
      logic [31:0] word;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 3)) push_scan(2'($urandom_range(0, 3)), $urandom());
         return;
      end
      case ($urandom_range(0, 7))
         0:       code = IR_IDCODE;
         1:       code = IR_IMPCODE;
         2:       code = IR_ADDRESS;
         3:       code = IR_DATA;
         4, 5:    code = IR_CONTROL;
         6:       code = IR_FASTDATA;
         default: code = 8'($urandom_range(0, 255));
      endcase
      push_scan(OP_IR_SHIFT, {24'($urandom()), code});
      repeat ($urandom_range(0, 3)) begin
         word = $urandom();
         if ($urandom_range(0, 1) == 1) begin
            if (code == IR_CONTROL && $urandom_range(0, 3) != 0) word[PRACC_BIT] = 1'b0;
            push_scan(OP_DR_IN, word);
         end else begin
            if (code == IR_CONTROL && $urandom_range(0, 3) != 0) word[PRACC_BIT] = 1'b1;
            push_scan(OP_DR_OUT, word);
         end
      end
      if ($urandom_range(0, 9) != 0) push_scan(OP_UPDATE, $urandom());
   endtask

   initial begin
      int target;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // update with reset selected, captured in word carried into IDCODE
      push_scan(OP_UPDATE,   32'h0000_0000);
      push_scan(OP_DR_IN,    32'hFFFF_FFFF);
      push_scan(OP_IR_SHIFT, {24'hFF_FFFF, IR_IDCODE});
      push_scan(OP_DR_OUT,   32'h1234_5678);
      push_scan(OP_UPDATE,   32'hFFFF_FFFF);
      push_scan(OP_IR_SHIFT, {24'd0, IR_IMPCODE});
      push_scan(OP_UPDATE,   32'h0000_0000);
      // fastdata echo
      push_scan(OP_IR_SHIFT, {24'd0, IR_FASTDATA});
      push_scan(OP_DR_IN,    32'h0000_0000);
      push_scan(OP_DR_OUT,   32'hFFFF_FFFF);
      push_scan(OP_UPDATE,   32'h0000_0000);
      // address, data, then a store access
      push_scan(OP_IR_SHIFT, {24'd0, IR_ADDRESS});
      push_scan(OP_DR_IN,    32'h0000_AAAA);
      push_scan(OP_DR_OUT,   32'hFF20_0000);
      push_scan(OP_UPDATE,   32'h0000_0000);
      push_scan(OP_IR_SHIFT, {24'd0, IR_DATA});
      push_scan(OP_DR_IN,    32'h5555_5555);
      push_scan(OP_DR_OUT,   32'hCAFE_F00D);
      push_scan(OP_UPDATE,   32'h0000_0000);
      push_scan(OP_IR_SHIFT, {24'd0, IR_CONTROL});
      push_scan(OP_DR_IN,    32'h0000_0000);
      push_scan(OP_DR_OUT,   (32'd1 << PRACC_BIT) | (32'd1 << PRNW_BIT));
      push_scan(OP_UPDATE,   32'h0000_0000);
      // load access with no captured data
      push_scan(OP_DR_OUT,   32'd1 << PRACC_BIT);
      push_scan(OP_UPDATE,   32'h0000_0000);
      push_scan(OP_IR_SHIFT, {24'd0, IR_LIST_EXTRA});
      push_scan(OP_IR_SHIFT, 32'hFFFF_FFFF);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 47;
            end
            1: begin
               send_idle_pct = 47;
               recv_idle_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_requests++;
            end
         endcase
         target = scan_items_queued + SEQ_ITEMS_PER_PHASE;
         while (scan_items_queued < target) queue_scan_sequence();
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS ejtag_scan_event_monitor_top");
      end else begin
         $display("FAIL ejtag_scan_event_monitor_top");
      end
      $finish;
   end

endmodule
